[rtl/core/qed_pkg.sv]
// Shared types, constants and helper functions for the quadrature edge decoder.
// No dependencies; qed_cfg, qed_core and the decoder top level use this package.
`timescale 1ns / 1ps

package qed_pkg;

  // Width of the position and clamped counts (supported range 8 to 64)
  localparam int unsigned COUNT_WIDTH = 32;
  // Working width for limit saturation and count resizing
  localparam int unsigned WORK_WIDTH = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

  // APB register map
  localparam int unsigned ADDR_WIDTH = 3;
  localparam logic REG_LOWER_LIMIT = 1'b0;
  localparam logic REG_UPPER_LIMIT = 1'b1;
  localparam logic signed [31:0] LOWER_LIMIT_RESET = 32'sh8000_0000;
  localparam logic signed [31:0] UPPER_LIMIT_RESET = 32'sh7FFF_FFFF;

  // Input actions
  localparam logic ACTION_EDGE   = 1'b0;
  localparam logic ACTION_PRESET = 1'b1;

  // Edge codes
  localparam logic [1:0] EDGE_A_RISE = 2'd0;
  localparam logic [1:0] EDGE_A_FALL = 2'd1;
  localparam logic [1:0] EDGE_B_RISE = 2'd2;
  localparam logic [1:0] EDGE_B_FALL = 2'd3;

  // Step kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CW   = 2'd1;
  localparam logic [1:0] KIND_CCW  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic              action;
    logic [1:0]        edge_req;
    logic [1:0]        pins_after;
    logic signed [31:0] preset_value;
  } evt_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] position_clamped;
    logic [31:0]        error_count;
    logic [1:0]         step_kind;
  } res_t;

  typedef struct packed {
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
  } limits_t;

  // Decode one edge against the pin levels (bit1 B, bit0 A) seen before it
  function automatic logic [1:0] step_of(input logic [1:0] ref_pins,
                                         input logic [1:0] edge_code);
    logic [1:0] kind;
    kind = KIND_ERR;
    case (ref_pins)
      2'b00: begin
        if (edge_code == EDGE_A_RISE) kind = KIND_CCW;
        else if (edge_code == EDGE_B_RISE) kind = KIND_CW;
      end
      2'b01: begin
        if (edge_code == EDGE_A_FALL) kind = KIND_CW;
        else if (edge_code == EDGE_B_RISE) kind = KIND_CCW;
      end
      2'b10: begin
        if (edge_code == EDGE_A_RISE) kind = KIND_CW;
        else if (edge_code == EDGE_B_FALL) kind = KIND_CCW;
      end
      default: begin
        if (edge_code == EDGE_A_FALL) kind = KIND_CCW;
        else if (edge_code == EDGE_B_FALL) kind = KIND_CW;
      end
    endcase
    return kind;
  endfunction

  // Resize a 32-bit signed value to the count width (truncate or sign-extend)
  function automatic count_t to_count(input logic signed [31:0] v);
    logic [WORK_WIDTH-1:0] ext;
    ext = {{(WORK_WIDTH-32){v[31]}}, v};
    return count_t'(ext[COUNT_WIDTH-1:0]);
  endfunction

  // Show a count on a 32-bit output: sign-extend, keep the low 32 bits
  function automatic logic signed [31:0] to_out(input count_t c);
    logic [WORK_WIDTH-1:0] ext;
    ext = {{(WORK_WIDTH-COUNT_WIDTH){c[COUNT_WIDTH-1]}}, c};
    return ext[31:0];
  endfunction

  // Saturate a 32-bit signed limit into the signed count range
  function automatic count_t fit_limit(input logic signed [31:0] v);
    logic signed [WORK_WIDTH-1:0] vx;
    logic signed [WORK_WIDTH-1:0] hi;
    logic signed [WORK_WIDTH-1:0] lo;
    count_t r;
    vx = {{(WORK_WIDTH-32){v[31]}}, v};
    hi = {{(WORK_WIDTH-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (vx > hi) r = count_t'(hi[COUNT_WIDTH-1:0]);
    else if (vx < lo) r = count_t'(lo[COUNT_WIDTH-1:0]);
    else r = count_t'(vx[COUNT_WIDTH-1:0]);
    return r;
  endfunction

endpackage

[rtl/core/qed_evt_if.sv]
// Edge event channel: valid/ready handshake with the input item fields.
// Depends on nothing; used by the decoder top level.
`timescale 1ns / 1ps

interface qed_evt_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [1:0]        edge_req;
  logic [1:0]        pins_after;
  logic signed [31:0] preset_value;

  modport source (output valid, action, edge_req, pins_after, preset_value, input ready);
  modport sink (input valid, action, edge_req, pins_after, preset_value, output ready);
endinterface

[rtl/core/qed_res_if.sv]
// Result channel: valid/ready handshake with the result item fields.
// Depends on nothing; used by the decoder top level.
`timescale 1ns / 1ps

interface qed_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] position;
  logic signed [31:0] position_clamped;
  logic [31:0]       error_count;
  logic [1:0]        step_kind;

  modport source (output valid, position, position_clamped, error_count, step_kind,
                  input ready);
  modport sink (input valid, position, position_clamped, error_count, step_kind,
                output ready);
endinterface

[rtl/core/qed_cfg.sv]
// APB register block holding the clamp limits.
// Depends on qed_pkg.
`timescale 1ns / 1ps

module qed_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qed_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output qed_pkg::limits_t                 limits
);

  logic signed [31:0] lower_limit;
  logic signed [31:0] upper_limit;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // Write the selected limit at the end of the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit <= qed_pkg::LOWER_LIMIT_RESET;
      upper_limit <= qed_pkg::UPPER_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        qed_pkg::REG_LOWER_LIMIT: lower_limit <= pwdata;
        qed_pkg::REG_UPPER_LIMIT: upper_limit <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      qed_pkg::REG_LOWER_LIMIT: prdata = lower_limit;
      qed_pkg::REG_UPPER_LIMIT: prdata = upper_limit;
      default: prdata = '0;
    endcase
  end

  assign limits.lower_limit = lower_limit;
  assign limits.upper_limit = upper_limit;

endmodule

[rtl/core/qed_core.sv]
// Decoder state (reference pins, counts, error count) and its per-beat update.
// Depends on qed_pkg.
`timescale 1ns / 1ps

module qed_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  qed_pkg::evt_t     item,
  input  qed_pkg::limits_t  limits,
  output qed_pkg::res_t     res_next
);

  logic [1:0]                           reference_pins;
  logic [qed_pkg::COUNT_WIDTH-1:0]      position_count;
  qed_pkg::count_t                      clamped_count;
  logic [31:0]                          illegal_count;

  logic [1:0]                           reference_pins_next;
  logic [qed_pkg::COUNT_WIDTH-1:0]      position_count_next;
  qed_pkg::count_t                      clamped_count_next;
  logic [31:0]                          illegal_count_next;

  logic [1:0]                           kind;
  qed_pkg::count_t                      lo_fit;
  qed_pkg::count_t                      hi_fit;
  logic signed [qed_pkg::COUNT_WIDTH:0] stepped;
  logic signed [qed_pkg::COUNT_WIDTH:0] lo_ext;
  logic signed [qed_pkg::COUNT_WIDTH:0] hi_ext;
  qed_pkg::count_t                      clamped_step;

  assign kind   = qed_pkg::step_of(reference_pins, item.edge_req);
  assign lo_fit = qed_pkg::fit_limit(limits.lower_limit);
  assign hi_fit = qed_pkg::fit_limit(limits.upper_limit);
  assign lo_ext = {lo_fit[qed_pkg::COUNT_WIDTH-1], lo_fit};
  assign hi_ext = {hi_fit[qed_pkg::COUNT_WIDTH-1], hi_fit};

  // Step the clamped count one place without wrapping, then clamp; lower wins
  always_comb begin
    if (kind == qed_pkg::KIND_CW) begin
      stepped = {clamped_count[qed_pkg::COUNT_WIDTH-1], clamped_count} + 1'sd1;
    end else begin
      stepped = {clamped_count[qed_pkg::COUNT_WIDTH-1], clamped_count} - 1'sd1;
    end
    if (stepped < lo_ext) clamped_step = lo_fit;
    else if (stepped > hi_ext) clamped_step = hi_fit;
    else clamped_step = qed_pkg::count_t'(stepped[qed_pkg::COUNT_WIDTH-1:0]);
  end

  // Next state for this beat
  always_comb begin
    reference_pins_next = item.pins_after;
    position_count_next = position_count;
    clamped_count_next  = clamped_count;
    illegal_count_next  = illegal_count;
    res_next.step_kind  = qed_pkg::KIND_NONE;
    if (item.action == qed_pkg::ACTION_PRESET) begin
      position_count_next = qed_pkg::to_count(item.preset_value);
      clamped_count_next  = qed_pkg::to_count(item.preset_value);
      illegal_count_next  = '0;
    end else begin
      res_next.step_kind = kind;
      case (kind)
        qed_pkg::KIND_CW: begin
          position_count_next = position_count + 1'b1;
          clamped_count_next  = clamped_step;
        end
        qed_pkg::KIND_CCW: begin
          position_count_next = position_count - 1'b1;
          clamped_count_next  = clamped_step;
        end
        default: illegal_count_next = illegal_count + 1'b1;
      endcase
    end
    res_next.position         = qed_pkg::to_out(position_count_next);
    res_next.position_clamped = qed_pkg::to_out(clamped_count_next);
    res_next.error_count      = illegal_count_next;
  end

  // Commit the state when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_pins <= '0;
      position_count <= '0;
      clamped_count  <= '0;
      illegal_count  <= '0;
    end else if (fire) begin
      reference_pins <= reference_pins_next;
      position_count <= position_count_next;
      clamped_count  <= clamped_count_next;
      illegal_count  <= illegal_count_next;
    end
  end

endmodule

[rtl/core/quadrature_edge_decoder.sv]
// Top level of the x4 quadrature edge decoder: input register, state update,
// result register and APB limits. Depends on qed_pkg, qed_evt_if, qed_res_if,
// qed_cfg and qed_core.
//
//   port       dir  handshake      carries
//   edge_evt   in   valid/ready    action, edge_req, pins_after, preset_value
//   result     out  valid/ready    position, position_clamped, error_count, step_kind
//   apb        in   psel/penable   lower_limit (0x0), upper_limit (0x4)
//
// Each beat passes from acceptance through the input register, then through
// the state update into the result register.
// One beat is accepted every cycle while results are taken; the state update
// is a single increment/clamp step, so back-to-back beats chain directly.
// When the result is not taken, the input register holds one more beat, then
// ready drops. Reset clears the counts, the reference pins and both valids.
`timescale 1ns / 1ps

module quadrature_edge_decoder (
  input  logic                           clk,
  input  logic                           rst,
  qed_evt_if.sink                        edge_evt,
  qed_res_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qed_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  qed_pkg::limits_t limits;
  qed_pkg::evt_t    stage;
  logic             stage_valid;
  qed_pkg::res_t    res_next;
  qed_pkg::res_t    res_q;
  logic             res_valid;
  logic             advance;
  logic             take_in;

  qed_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // Move the staged beat on when the result register is free or being emptied
  assign advance        = stage_valid & (~res_valid | result.ready);
  assign edge_evt.ready = ~stage_valid | advance;
  assign take_in        = edge_evt.valid & edge_evt.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (edge_evt.ready) begin
      stage_valid <= edge_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      stage.action       <= edge_evt.action;
      stage.edge_req     <= edge_evt.edge_req;
      stage.pins_after   <= edge_evt.pins_after;
      stage.preset_value <= edge_evt.preset_value;
    end
  end

  qed_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (stage),
    .limits   (limits),
    .res_next (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid            = res_valid;
  assign result.position         = res_q.position;
  assign result.position_clamped = res_q.position_clamped;
  assign result.error_count      = res_q.error_count;
  assign result.step_kind        = res_q.step_kind;

  // A preset result always shows a cleared error count
  a_preset_clears_errors: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.step_kind == qed_pkg::KIND_NONE) |-> (result.error_count == '0))
    else $error("preset result with nonzero error count");

  // A staged beat that cannot move on stays staged
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid)
    else $error("staged beat dropped while result register full");

  // Ready drops only with a beat waiting in the input register
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (rst)
    !edge_evt.ready |-> (stage_valid && res_valid))
    else $error("input stalled with free storage");

  // An error beat moves the error count by one from the previous result
  a_error_increments: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && result.ready && stage.action == qed_pkg::ACTION_EDGE &&
     res_next.step_kind == qed_pkg::KIND_ERR)
    |-> (res_next.error_count == result.error_count + 32'd1))
    else $error("error count did not advance on an illegal transition");

endmodule

[tb/tb_quadrature_edge_decoder.sv]
// Self-checking bench for the quadrature edge decoder: directed edge walks, then
// randomized encoder motion over several limit windows, checked against a local decoder.
// Depends on qed_pkg, qed_evt_if, qed_res_if and the quadrature_edge_decoder RTL.
`timescale 1ns / 1ps

module tb_quadrature_edge_decoder;
  import qed_pkg::*;

  localparam int unsigned CNT_W = COUNT_WIDTH;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef logic signed [65:0] wide_t;

  localparam wide_t COUNT_MAX = (wide_t'(1) <<< (CNT_W - 1)) - 1;
  localparam wide_t COUNT_MIN = -COUNT_MAX - 1;

  // Next pin state (B,A) one step clockwise / counter-clockwise
  localparam logic [1:0] CW_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};
  localparam logic [1:0] CCW_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  qed_evt_if edge_if ();
  qed_res_if result_if ();

  quadrature_edge_decoder dut (
    .clk(clk),
    .rst(rst),
    .edge_evt(edge_if),
    .result(result_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Decoder state as seen by the checker
  logic [1:0] last_pins = 2'b00;
  logic signed [CNT_W-1:0] pos_count = '0;
  logic signed [CNT_W-1:0] clamp_count = '0;
  logic [31:0] bad_count = '0;
  logic signed [31:0] lim_lo = LOWER_LIMIT_RESET;
  logic signed [31:0] lim_hi = UPPER_LIMIT_RESET;

  res_t predicted_counts [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  logic [1:0] drive_pins = 2'b00;
  bit steady = 1'b0;
  bit rx_hold = 1'b0;

  typedef struct {
    logic act;
    logic [1:0] edge_code;
    logic [1:0] pins;
    logic [31:0] preset;
    bit typed;
    logic [31:0] pos;
    logic [31:0] clamp;
    logic [31:0] errs;
    logic [1:0] kind;
  } script_row_t;

  // Full turn each way, errors on every reference state, preset extremes and wrap
  script_row_t script [23] = '{
    '{ACTION_EDGE, EDGE_B_RISE, 2'b10, 32'h0, 1'b1, 32'd1, 32'd1, 32'd0, KIND_CW},
    '{ACTION_EDGE, EDGE_A_RISE, 2'b11, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_FALL, 2'b01, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_FALL, 2'b00, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_RISE, 2'b01, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_RISE, 2'b11, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_FALL, 2'b10, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_FALL, 2'b00, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_FALL, 2'b00, 32'h0, 1'b1, 32'd0, 32'd0, 32'd1, KIND_ERR},
    '{ACTION_EDGE, EDGE_B_FALL, 2'b00, 32'h0, 1'b1, 32'd0, 32'd0, 32'd2, KIND_ERR},
    '{ACTION_PRESET, EDGE_B_FALL, 2'b00, 32'h7FFF_FFFF, 1'b1,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_RISE, 2'b10, 32'h0, 1'b1,
      32'h8000_0000, 32'h7FFF_FFFF, 32'd0, KIND_CW},
    '{ACTION_PRESET, EDGE_A_RISE, 2'b11, 32'h8000_0000, 1'b1,
      32'h8000_0000, 32'h8000_0000, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_FALL, 2'b10, 32'h0, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'd0, KIND_CCW},
    '{ACTION_EDGE, EDGE_A_FALL, 2'b01, 32'h0, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'd1, KIND_ERR},
    '{ACTION_EDGE, EDGE_A_RISE, 2'b11, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_RISE, 2'b11, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_RISE, 2'b00, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_RISE, 2'b10, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_RISE, 2'b10, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_B_FALL, 2'b11, 32'h0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_NONE},
    '{ACTION_PRESET, EDGE_A_FALL, 2'b10, 32'hFFFF_FFFF, 1'b1,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, KIND_NONE},
    '{ACTION_EDGE, EDGE_A_RISE, 2'b11, 32'h0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_CW}
  };

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Saturate a 32-bit limit into the signed count range
  function automatic wide_t limit_in_range(input logic signed [31:0] lim);
    wide_t v;
    v = lim;
    if (v > COUNT_MAX) v = COUNT_MAX;
    else if (v < COUNT_MIN) v = COUNT_MIN;
    return v;
  endfunction

  // Advance the decoder state by one beat and return what it should report
  function automatic res_t decode_edge(input evt_t b);
    wide_t v;
    logic [1:0] moved;
    logic is_b;
    logic rising;
    res_t r;
    r.step_kind = KIND_NONE;
    if (b.action == ACTION_PRESET) begin
      pos_count = b.preset_value;
      clamp_count = b.preset_value;
      bad_count = '0;
    end else begin
      // Apply the named edge to the old pins; no change means an illegal edge
      is_b = (b.edge_req == EDGE_B_RISE) || (b.edge_req == EDGE_B_FALL);
      rising = (b.edge_req == EDGE_A_RISE) || (b.edge_req == EDGE_B_RISE);
      moved = last_pins;
      if (is_b) moved[1] = rising;
      else moved[0] = rising;
      if (moved == last_pins) r.step_kind = KIND_ERR;
      else if (moved == CW_NEXT[last_pins]) r.step_kind = KIND_CW;
      else r.step_kind = KIND_CCW;

      if (r.step_kind == KIND_ERR) begin
        bad_count = bad_count + 1'b1;
      end else begin
        v = clamp_count;
        if (r.step_kind == KIND_CW) begin
          pos_count = pos_count + 1'b1;
          v = v + 1;
        end else begin
          pos_count = pos_count - 1'b1;
          v = v - 1;
        end
        // Lower bound wins when the window is inverted
        if (v < limit_in_range(lim_lo)) v = limit_in_range(lim_lo);
        else if (v > limit_in_range(lim_hi)) v = limit_in_range(lim_hi);
        clamp_count = v[CNT_W-1:0];
      end
    end
    last_pins = b.pins_after;
    v = pos_count;
    r.position = v[31:0];
    v = clamp_count;
    r.position_clamped = v[31:0];
    r.error_count = bad_count;
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Offer one beat, idling at random first, and hold it until taken
  task automatic push_beat(input evt_t b);
    while (!steady && $urandom_range(99) < 32) begin
      edge_if.valid <= 1'b0;
      @(posedge clk);
    end
    edge_if.valid <= 1'b1;
    edge_if.action <= b.action;
    edge_if.edge_req <= b.edge_req;
    edge_if.pins_after <= b.pins_after;
    edge_if.preset_value <= b.preset_value;
    do @(posedge clk); while (!edge_if.ready);
    beats_sent++;
    drive_pins = b.pins_after;
  endtask

  // Drop valid and wait for every owed result plus the pipeline depth
  task automatic quiesce();
    edge_if.valid <= 1'b0;
    while (predicted_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one limit register, then read it back
  task automatic apb_write(input logic idx, input logic [31:0] value);
    logic [ADDR_WIDTH-1:0] addr;
    addr = ADDR_WIDTH'(idx) << 2;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      flag($sformatf("limit readback at 0x%0h: exp %h got %h", addr, value, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Retune the clamp window, then drive a stretch of encoder motion
  task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                           input int unsigned beats, input bit calm);
    evt_t b;
    bit cw_dir;
    int unsigned roll;
    logic [1:0] target;
    logic [1:0] changed;
    quiesce();
    apb_write(REG_LOWER_LIMIT, lo);
    apb_write(REG_UPPER_LIMIT, hi);
    lim_lo = lo;
    lim_hi = hi;
    steady <= calm;
    cw_dir = 1'($urandom_range(1));
    for (int unsigned n = 0; n < beats; n++) begin
      roll = $urandom_range(99);
      b.action = ACTION_EDGE;
      b.preset_value = $urandom;
      b.edge_req = 2'($urandom_range(3));
      b.pins_after = 2'($urandom_range(3));
      if (roll < 5) begin
        // Preset anywhere, or close to a limit or zero so the clamp gets hit
        b.action = ACTION_PRESET;
        case ($urandom_range(3))
          0: b.preset_value = $urandom;
          1: b.preset_value = lim_lo + $urandom_range(16) - 8;
          2: b.preset_value = lim_hi + $urandom_range(16) - 8;
          default: b.preset_value = $urandom_range(40) - 20;
        endcase
      end else if (roll >= 17) begin
        // Legal step, direction changes now and then
        if ($urandom_range(99) < 6) cw_dir = !cw_dir;
        target = cw_dir ? CW_NEXT[drive_pins] : CCW_NEXT[drive_pins];
        changed = target ^ drive_pins;
        if (changed[1]) b.edge_req = target[1] ? EDGE_B_RISE : EDGE_B_FALL;
        else b.edge_req = target[0] ? EDGE_A_RISE : EDGE_A_FALL;
        b.pins_after = target;
      end
      push_beat(b);
      predicted_counts.push_back(decode_edge(b));
    end
    steady <= 1'b0;
  endtask

  // Receiver: random back-pressure, off in steady stretches; ready is held low during the hold
  always @(posedge clk) begin
    result_if.ready <= !rx_hold && (steady || $urandom_range(99) >= 32);
  end

  // Long hold-off on results while the sender keeps offering beats
  initial begin
    while (beats_sent < HOLD_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      seen.position = result_if.position;
      seen.position_clamped = result_if.position_clamped;
      seen.error_count = result_if.error_count;
      seen.step_kind = result_if.step_kind;
      if (predicted_counts.size() == 0) begin
        flag($sformatf("result with nothing owed: pos %h clamp %h err %h kind %0d",
                       seen.position, seen.position_clamped, seen.error_count,
                       seen.step_kind));
      end else begin
        want = predicted_counts.pop_front();
        if (seen.position !== want.position ||
            seen.position_clamped !== want.position_clamped ||
            seen.error_count !== want.error_count ||
            seen.step_kind !== want.step_kind)
          flag($sformatf({"result mismatch: pos exp %h got %h, clamp exp %h got %h, ",
                          "err exp %h got %h, kind exp %0d got %0d"},
                         want.position, seen.position,
                         want.position_clamped, seen.position_clamped,
                         want.error_count, seen.error_count,
                         want.step_kind, seen.step_kind));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    evt_t b;
    res_t p;
    logic [31:0] w_lo;
    edge_if.valid = 1'b0;
    edge_if.action = ACTION_EDGE;
    edge_if.edge_req = EDGE_A_RISE;
    edge_if.pins_after = 2'b00;
    edge_if.preset_value = '0;
    result_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed walk under reset limits
    foreach (script[i]) begin
      b.action = script[i].act;
      b.edge_req = script[i].edge_code;
      b.pins_after = script[i].pins;
      b.preset_value = script[i].preset;
      push_beat(b);
      p = decode_edge(b);
      if (script[i].typed) begin
        p.position = script[i].pos;
        p.position_clamped = script[i].clamp;
        p.error_count = script[i].errs;
        p.step_kind = script[i].kind;
      end
      predicted_counts.push_back(p);
    end

    // Random motion over a series of clamp windows, extremes included
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 200, 1'b0);
    run_phase(-32'sd6, 32'sd6, 200, 1'b0);
    run_phase(32'd0, 32'd0, 150, 1'b1);
    run_phase(32'sd7, -32'sd7, 150, 1'b0);
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 150, 1'b0);
    run_phase(32'h8000_0000, 32'h8000_0000, 150, 1'b0);
    w_lo = $urandom;
    run_phase(w_lo, w_lo + $urandom_range(64), 200, 1'b0);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 150, 1'b0);

    quiesce();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[quadrature_edge_decoder.f]
rtl/core/qed_pkg.sv
rtl/core/qed_evt_if.sv
rtl/core/qed_res_if.sv
rtl/core/qed_cfg.sv
rtl/core/qed_core.sv
rtl/core/quadrature_edge_decoder.sv
tb/tb_quadrature_edge_decoder.sv
